[design/pnf_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants of the fractal Perlin noise block.
package pnf_pkg;

    localparam int TABLE_SIZE_DEF  = 256;
    localparam int MAX_OCTAVES_DEF = 16;

    // Field and datapath widths.
    localparam int PERM_W     = 8;
    localparam int GRAD_W     = 16;
    localparam int POINT_W    = 24;
    localparam int HEIGHT_W   = 21;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier operand and product widths.
    localparam int MA_W = 33;
    localparam int MB_W = 18;
    localparam int P_W  = MA_W + MB_W;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_OCTAVES = 2'd0;
    localparam logic [1:0] REG_GAIN    = 2'd1;
    localparam logic [1:0] REG_FREQ    = 2'd2;

    // Register reset values.
    localparam logic [4:0]  OCTAVES_RST = 5'd10;
    localparam logic [15:0] GAIN_RST    = 16'd19859;
    localparam logic [15:0] FREQ_RST    = 16'd9011;

    // Operation codes of an input item.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic [4:0]  octave_count;
        logic [15:0] inverse_gain;
        logic [15:0] frequency_step;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7,
        ST_DX, ST_DY, ST_DS,
        ST_L0, ST_L1, ST_L2, ST_L3, ST_L4, ST_L5,
        ST_L6, ST_L7, ST_L8, ST_L9, ST_L10, ST_L11,
        ST_FIN
    } state_t;

endpackage

[design/pnf_cfg.sv]
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
module pnf_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pnf_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pnf_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pnf_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output pnf_pkg::cfg_t                     cfg
);

    pnf_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.octave_count   <= pnf_pkg::OCTAVES_RST;
            cfg_reg.inverse_gain   <= pnf_pkg::GAIN_RST;
            cfg_reg.frequency_step <= pnf_pkg::FREQ_RST;
        end
        else if (wr_en)
        begin
            if (reg_idx == pnf_pkg::REG_OCTAVES)
            begin
                cfg_reg.octave_count <= pwdata[4:0];
            end
            if (reg_idx == pnf_pkg::REG_GAIN)
            begin
                cfg_reg.inverse_gain <= pwdata[15:0];
            end
            if (reg_idx == pnf_pkg::REG_FREQ)
            begin
                cfg_reg.frequency_step <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            pnf_pkg::REG_OCTAVES: prdata = {27'd0, cfg_reg.octave_count};
            pnf_pkg::REG_GAIN:    prdata = {16'd0, cfg_reg.inverse_gain};
            pnf_pkg::REG_FREQ:    prdata = {16'd0, cfg_reg.frequency_step};
            default:              prdata = '0;
        endcase
    end

endmodule

[design/pnf_tables.sv]
`timescale 1ns / 1ps
// Permutation and gradient tables with one write port and registered reads.
module pnf_tables #(
    parameter int TABLE_SIZE = pnf_pkg::TABLE_SIZE_DEF
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [$clog2(TABLE_SIZE)-1:0]         waddr,
    input  logic [pnf_pkg::PERM_W-1:0]            wperm,
    input  logic signed [pnf_pkg::GRAD_W-1:0]     wgrad_x,
    input  logic signed [pnf_pkg::GRAD_W-1:0]     wgrad_y,
    input  logic [$clog2(TABLE_SIZE)-1:0]         perm_raddr,
    input  logic [$clog2(TABLE_SIZE)-1:0]         grad_raddr,
    output logic [pnf_pkg::PERM_W-1:0]            perm_rdata,
    output logic signed [pnf_pkg::GRAD_W-1:0]     grad_x_rdata,
    output logic signed [pnf_pkg::GRAD_W-1:0]     grad_y_rdata
);

    logic [pnf_pkg::PERM_W-1:0]     perm_mem [TABLE_SIZE];
    logic [2*pnf_pkg::GRAD_W-1:0]   grad_mem [TABLE_SIZE];
    logic [pnf_pkg::PERM_W-1:0]     perm_q_reg;
    logic [2*pnf_pkg::GRAD_W-1:0]   grad_q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            perm_mem[waddr] <= wperm;
            grad_mem[waddr] <= {wgrad_x, wgrad_y};
        end
        perm_q_reg <= perm_mem[perm_raddr];
        grad_q_reg <= grad_mem[grad_raddr];
    end

    assign perm_rdata   = perm_q_reg;
    assign grad_x_rdata = $signed(grad_q_reg[2*pnf_pkg::GRAD_W-1:pnf_pkg::GRAD_W]);
    assign grad_y_rdata = $signed(grad_q_reg[pnf_pkg::GRAD_W-1:0]);

endmodule

[design/pnf_mul.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module pnf_mul (
    input  logic                             clk,
    input  logic signed [pnf_pkg::MA_W-1:0]  a,
    input  logic signed [pnf_pkg::MB_W-1:0]  b,
    output logic signed [pnf_pkg::P_W-1:0]   prod
);

    logic signed [pnf_pkg::P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

[design/perlin_noise_fbm_2d.sv]
`timescale 1ns / 1ps
// Top level: sequencer and datapath of the fractal 2D Perlin noise block.
//
// Input channel (in_valid/in_stall) carries load and evaluate items. A load
// writes one permutation entry and one gradient entry; the next item may
// follow right after it. An evaluate runs through the same sequence of states
// for every octave, and the next item can be accepted as soon as its result
// is valid. The default is ten octaves. Every product of an octave goes
// through the one shared multiplier; table reads overlap with the s-curve
// products. in_stall is high for the whole evaluation.
// Output channel (out_valid/out_stall) carries one height per evaluate from an
// output register. When the receiver stalls, the register holds its result;
// the next evaluate still runs and waits at its end until the register frees.
// Reset clears the sequencer and the output valid flag and sets the
// configuration registers to their reset values. The tables are not cleared:
// a point must only touch entries that were loaded before. Configuration is
// written through the APB-style port.
module perlin_noise_fbm_2d #(
    parameter int TABLE_SIZE  = pnf_pkg::TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = pnf_pkg::MAX_OCTAVES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic [7:0]                           table_index,
    input  logic [pnf_pkg::PERM_W-1:0]           perm_value,
    input  logic signed [pnf_pkg::GRAD_W-1:0]    grad_x,
    input  logic signed [pnf_pkg::GRAD_W-1:0]    grad_y,
    input  logic signed [pnf_pkg::POINT_W-1:0]   point_x,
    input  logic signed [pnf_pkg::POINT_W-1:0]   point_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pnf_pkg::HEIGHT_W-1:0]  height,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pnf_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [pnf_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [pnf_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int OCT_W   = $clog2(MAX_OCTAVES + 1);
    localparam int PX_W    = 48;
    localparam int FRAC_W  = 12;
    localparam int OFS_W   = FRAC_W + 1;
    localparam int SC_W    = 17;
    localparam int T2_W    = 2 * FRAC_W;
    localparam int T3_W    = 3 * FRAC_W;
    localparam int TMP_W   = 28;
    localparam int DOT_W   = 29;
    localparam int LRP_W   = 30;
    localparam int NOISE_W = 20;
    localparam int AMP_W   = 17;
    localparam int SUM_W   = 26;
    localparam int HALF_W  = PX_W / 2;
    localparam int HIP_W   = 60 - HALF_W;
    localparam int LOP_W   = HALF_W + 16;

    localparam logic signed [pnf_pkg::P_W-1:0]  HALF16 = pnf_pkg::P_W'(32768);
    localparam logic signed [pnf_pkg::GRAD_W-1:0] GRAD_LIMIT = 16'sd16384;
    localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;
    localparam logic signed [SUM_W-1:0] HEIGHT_MAX = SUM_W'(1048575);
    localparam logic signed [SUM_W-1:0] HEIGHT_MIN = -SUM_W'(1048576);

    pnf_pkg::state_t state_reg, state_next;
    pnf_pkg::cfg_t   cfg;

    logic signed [PX_W-1:0]    px_reg, py_reg;
    logic [AMP_W-1:0]          amp_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [OCT_W-1:0]          oct_reg, n_reg, n_eff;
    logic [IDX_W-1:0]          hi_reg, hj_reg;
    logic [T2_W-1:0]           tx2_reg, ty2_reg;
    logic [SC_W-1:0]           sx_reg, sy_reg;
    logic signed [pnf_pkg::GRAD_W-1:0] gx_reg [4];
    logic signed [pnf_pkg::GRAD_W-1:0] gy_reg [4];
    logic [1:0]                k_reg;
    logic signed [TMP_W-1:0]   tmp_reg;
    logic signed [DOT_W-1:0]   dot_reg [4];
    logic signed [LRP_W-1:0]   la_reg, lb_reg;
    logic signed [NOISE_W-1:0] noise_reg;
    logic [HIP_W-1:0]          hip_reg;
    logic                      out_valid_reg;
    logic signed [pnf_pkg::HEIGHT_W-1:0] height_reg;

    logic                      in_acc, load_we, fin_load;
    logic [IDX_W-1:0]          bx0, bx1, by0, by1, perm_raddr, grad_raddr;
    logic [FRAC_W-1:0]         frac_x, frac_y;
    logic signed [OFS_W-1:0]   rx0, rx1, ry0, ry1;
    logic [pnf_pkg::PERM_W-1:0] perm_rdata;
    logic signed [pnf_pkg::GRAD_W-1:0] grad_x_rd, grad_y_rd, gx_clamp, gy_clamp;
    logic signed [pnf_pkg::MA_W-1:0] mul_a;
    logic signed [pnf_pkg::MB_W-1:0] mul_b;
    logic signed [pnf_pkg::P_W-1:0]  prod, prod_r16;
    logic signed [DOT_W:0]     diff_a, diff_b;
    logic signed [LRP_W:0]     diff_y, lerp_y;
    logic [39:0]               sc_val;
    logic [59:0]               scale_sum;
    logic [5:0]                oct_req;

    function automatic logic signed [pnf_pkg::GRAD_W-1:0] clamp_grad(
        input logic signed [pnf_pkg::GRAD_W-1:0] g
    );
        logic signed [pnf_pkg::GRAD_W-1:0] r;
        r = g;
        if (g > GRAD_LIMIT)
        begin
            r = GRAD_LIMIT;
        end
        if (g < -GRAD_LIMIT)
        begin
            r = -GRAD_LIMIT;
        end
        return r;
    endfunction

    // s-curve 3t^2 - 2t^3 in Q0.16, from t^2 and t^3 of a Q0.12 offset.
    function automatic logic [SC_W-1:0] s_curve(
        input logic [T2_W-1:0] t2,
        input logic [T3_W-1:0] t3
    );
        logic [39:0] v;
        v = (40'(t2) << 13) + (40'(t2) << 12) - (40'(t3) << 1) + 40'd524288;
        return v[20 +: SC_W];
    endfunction

    pnf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pnf_tables #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_tables (
        .clk          (clk),
        .we           (load_we),
        .waddr        (IDX_W'(table_index)),
        .wperm        (perm_value),
        .wgrad_x      (gx_clamp),
        .wgrad_y      (gy_clamp),
        .perm_raddr   (perm_raddr),
        .grad_raddr   (grad_raddr),
        .perm_rdata   (perm_rdata),
        .grad_x_rdata (grad_x_rd),
        .grad_y_rdata (grad_y_rd)
    );

    pnf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign in_stall  = (state_reg != pnf_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign load_we   = in_acc && (operation == pnf_pkg::OP_LOAD);
    assign fin_load  = (state_reg == pnf_pkg::ST_FIN) && (!out_valid_reg || !out_stall);
    assign gx_clamp  = clamp_grad(grad_x);
    assign gy_clamp  = clamp_grad(grad_y);
    assign out_valid = out_valid_reg;
    assign height    = height_reg;

    // Lattice cell and offsets of the current octave.
    assign bx0    = px_reg[FRAC_W +: IDX_W];
    assign by0    = py_reg[FRAC_W +: IDX_W];
    assign bx1    = bx0 + 1'b1;
    assign by1    = by0 + 1'b1;
    assign frac_x = px_reg[FRAC_W-1:0];
    assign frac_y = py_reg[FRAC_W-1:0];
    // The offset minus one is the same fraction with the sign bit set.
    assign rx0    = $signed({1'b0, frac_x});
    assign rx1    = $signed({1'b1, frac_x});
    assign ry0    = $signed({1'b0, frac_y});
    assign ry1    = $signed({1'b1, frac_y});

    assign prod_r16  = (prod + HALF16) >>> 16;
    assign diff_a    = (DOT_W+1)'(dot_reg[2]) - (DOT_W+1)'(dot_reg[0]);
    assign diff_b    = (DOT_W+1)'(dot_reg[3]) - (DOT_W+1)'(dot_reg[1]);
    assign diff_y    = (LRP_W+1)'(lb_reg) - (LRP_W+1)'(la_reg);
    assign lerp_y    = (LRP_W+1)'(la_reg) + (LRP_W+1)'(prod_r16);
    assign sc_val    = 40'(s_curve(tx2_reg, prod[T3_W-1:0]));
    assign scale_sum = {hip_reg, {HALF_W{1'b0}}} + 60'(prod[LOP_W-1:0]) + 60'd2048;
    assign oct_req   = {1'b0, cfg.octave_count};
    assign n_eff     = (oct_req > 6'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                   : OCT_W'(cfg.octave_count);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pnf_pkg::ST_IDLE:
            begin
                if (in_acc && operation == pnf_pkg::OP_EVAL)
                begin
                    state_next = (n_eff == '0) ? pnf_pkg::ST_FIN : pnf_pkg::ST_H0;
                end
            end
            pnf_pkg::ST_H0:  state_next = pnf_pkg::ST_H1;
            pnf_pkg::ST_H1:  state_next = pnf_pkg::ST_H2;
            pnf_pkg::ST_H2:  state_next = pnf_pkg::ST_H3;
            pnf_pkg::ST_H3:  state_next = pnf_pkg::ST_H4;
            pnf_pkg::ST_H4:  state_next = pnf_pkg::ST_H5;
            pnf_pkg::ST_H5:  state_next = pnf_pkg::ST_H6;
            pnf_pkg::ST_H6:  state_next = pnf_pkg::ST_H7;
            pnf_pkg::ST_H7:  state_next = pnf_pkg::ST_DX;
            pnf_pkg::ST_DX:  state_next = pnf_pkg::ST_DY;
            pnf_pkg::ST_DY:  state_next = pnf_pkg::ST_DS;
            pnf_pkg::ST_DS:  state_next = (k_reg == 2'd3) ? pnf_pkg::ST_L0 : pnf_pkg::ST_DX;
            pnf_pkg::ST_L0:  state_next = pnf_pkg::ST_L1;
            pnf_pkg::ST_L1:  state_next = pnf_pkg::ST_L2;
            pnf_pkg::ST_L2:  state_next = pnf_pkg::ST_L3;
            pnf_pkg::ST_L3:  state_next = pnf_pkg::ST_L4;
            pnf_pkg::ST_L4:  state_next = pnf_pkg::ST_L5;
            pnf_pkg::ST_L5:  state_next = pnf_pkg::ST_L6;
            pnf_pkg::ST_L6:  state_next = pnf_pkg::ST_L7;
            pnf_pkg::ST_L7:  state_next = pnf_pkg::ST_L8;
            pnf_pkg::ST_L8:  state_next = pnf_pkg::ST_L9;
            pnf_pkg::ST_L9:  state_next = pnf_pkg::ST_L10;
            pnf_pkg::ST_L10: state_next = pnf_pkg::ST_L11;
            pnf_pkg::ST_L11:
            begin
                state_next = (oct_reg + 1'b1 == n_reg) ? pnf_pkg::ST_FIN : pnf_pkg::ST_H0;
            end
            pnf_pkg::ST_FIN:
            begin
                if (fin_load)
                begin
                    state_next = pnf_pkg::ST_IDLE;
                end
            end
            default: state_next = pnf_pkg::ST_IDLE;
        endcase
    end

    // Table addresses and multiplier operands.
    always_comb
    begin
        perm_raddr = '0;
        grad_raddr = '0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            pnf_pkg::ST_H0:
            begin
                perm_raddr = bx0;
                mul_a = pnf_pkg::MA_W'(frac_x);
                mul_b = pnf_pkg::MB_W'(frac_x);
            end
            pnf_pkg::ST_H1:
            begin
                perm_raddr = bx1;
                mul_a = pnf_pkg::MA_W'(prod[T2_W-1:0]);
                mul_b = pnf_pkg::MB_W'(frac_x);
            end
            pnf_pkg::ST_H2:
            begin
                perm_raddr = hi_reg + by0;
                mul_a = pnf_pkg::MA_W'(frac_y);
                mul_b = pnf_pkg::MB_W'(frac_y);
            end
            pnf_pkg::ST_H3:
            begin
                perm_raddr = hi_reg + by1;
                grad_raddr = IDX_W'(perm_rdata);
                mul_a = pnf_pkg::MA_W'(prod[T2_W-1:0]);
                mul_b = pnf_pkg::MB_W'(frac_y);
            end
            pnf_pkg::ST_H4:
            begin
                perm_raddr = hj_reg + by0;
                grad_raddr = IDX_W'(perm_rdata);
            end
            pnf_pkg::ST_H5:
            begin
                perm_raddr = hj_reg + by1;
                grad_raddr = IDX_W'(perm_rdata);
            end
            pnf_pkg::ST_H6:
            begin
                grad_raddr = IDX_W'(perm_rdata);
            end
            pnf_pkg::ST_DX:
            begin
                mul_a = pnf_pkg::MA_W'(gx_reg[k_reg]);
                mul_b = pnf_pkg::MB_W'(k_reg[1] ? rx1 : rx0);
            end
            pnf_pkg::ST_DY:
            begin
                mul_a = pnf_pkg::MA_W'(gy_reg[k_reg]);
                mul_b = pnf_pkg::MB_W'(k_reg[0] ? ry1 : ry0);
            end
            pnf_pkg::ST_L0:
            begin
                mul_a = pnf_pkg::MA_W'(diff_a);
                mul_b = $signed(pnf_pkg::MB_W'(sx_reg));
            end
            pnf_pkg::ST_L1:
            begin
                mul_a = pnf_pkg::MA_W'(diff_b);
                mul_b = $signed(pnf_pkg::MB_W'(sx_reg));
            end
            pnf_pkg::ST_L3:
            begin
                mul_a = pnf_pkg::MA_W'(diff_y);
                mul_b = $signed(pnf_pkg::MB_W'(sy_reg));
            end
            pnf_pkg::ST_L5:
            begin
                mul_a = pnf_pkg::MA_W'(noise_reg);
                mul_b = $signed(pnf_pkg::MB_W'(amp_reg));
            end
            pnf_pkg::ST_L6:
            begin
                mul_a = pnf_pkg::MA_W'(amp_reg);
                mul_b = $signed(pnf_pkg::MB_W'(cfg.inverse_gain));
            end
            pnf_pkg::ST_L7:
            begin
                // The upper half carries the sign of the point.
                mul_a = pnf_pkg::MA_W'($signed(px_reg[PX_W-1:HALF_W]));
                mul_b = $signed(pnf_pkg::MB_W'(cfg.frequency_step));
            end
            pnf_pkg::ST_L8:
            begin
                mul_a = $signed(pnf_pkg::MA_W'(px_reg[HALF_W-1:0]));
                mul_b = $signed(pnf_pkg::MB_W'(cfg.frequency_step));
            end
            pnf_pkg::ST_L9:
            begin
                mul_a = pnf_pkg::MA_W'($signed(py_reg[PX_W-1:HALF_W]));
                mul_b = $signed(pnf_pkg::MB_W'(cfg.frequency_step));
            end
            pnf_pkg::ST_L10:
            begin
                mul_a = $signed(pnf_pkg::MA_W'(py_reg[HALF_W-1:0]));
                mul_b = $signed(pnf_pkg::MB_W'(cfg.frequency_step));
            end
            default:
            begin
                perm_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pnf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            pnf_pkg::ST_IDLE:
            begin
                if (in_acc && operation == pnf_pkg::OP_EVAL)
                begin
                    px_reg  <= PX_W'(point_x);
                    py_reg  <= PX_W'(point_y);
                    amp_reg <= AMP_ONE;
                    sum_reg <= '0;
                    oct_reg <= '0;
                    n_reg   <= n_eff;
                end
            end
            pnf_pkg::ST_H0:
            begin
                k_reg <= 2'd0;
            end
            pnf_pkg::ST_H1:
            begin
                hi_reg  <= IDX_W'(perm_rdata);
                tx2_reg <= prod[T2_W-1:0];
            end
            pnf_pkg::ST_H2:
            begin
                hj_reg <= IDX_W'(perm_rdata);
                sx_reg <= sc_val[SC_W-1:0];
            end
            pnf_pkg::ST_H3:
            begin
                ty2_reg <= prod[T2_W-1:0];
            end
            pnf_pkg::ST_H4:
            begin
                sy_reg    <= s_curve(ty2_reg, prod[T3_W-1:0]);
                gx_reg[0] <= grad_x_rd;
                gy_reg[0] <= grad_y_rd;
            end
            pnf_pkg::ST_H5:
            begin
                gx_reg[1] <= grad_x_rd;
                gy_reg[1] <= grad_y_rd;
            end
            pnf_pkg::ST_H6:
            begin
                gx_reg[2] <= grad_x_rd;
                gy_reg[2] <= grad_y_rd;
            end
            pnf_pkg::ST_H7:
            begin
                gx_reg[3] <= grad_x_rd;
                gy_reg[3] <= grad_y_rd;
            end
            pnf_pkg::ST_DY:
            begin
                tmp_reg <= prod[TMP_W-1:0];
            end
            pnf_pkg::ST_DS:
            begin
                dot_reg[k_reg] <= DOT_W'(tmp_reg) + DOT_W'($signed(prod[TMP_W-1:0]));
                k_reg          <= k_reg + 1'b1;
            end
            pnf_pkg::ST_L1:
            begin
                la_reg <= LRP_W'(dot_reg[0]) + LRP_W'(prod_r16);
            end
            pnf_pkg::ST_L2:
            begin
                lb_reg <= LRP_W'(dot_reg[1]) + LRP_W'(prod_r16);
            end
            pnf_pkg::ST_L4:
            begin
                noise_reg <= NOISE_W'((lerp_y + (LRP_W+1)'(512)) >>> 10);
            end
            pnf_pkg::ST_L6:
            begin
                sum_reg <= sum_reg + SUM_W'(prod_r16);
            end
            pnf_pkg::ST_L7:
            begin
                amp_reg <= AMP_W'(prod_r16);
            end
            pnf_pkg::ST_L8, pnf_pkg::ST_L10:
            begin
                hip_reg <= prod[HIP_W-1:0];
            end
            pnf_pkg::ST_L9:
            begin
                px_reg <= $signed(scale_sum[59:FRAC_W]);
            end
            pnf_pkg::ST_L11:
            begin
                py_reg  <= $signed(scale_sum[59:FRAC_W]);
                oct_reg <= oct_reg + 1'b1;
            end
            pnf_pkg::ST_FIN:
            begin
                if (fin_load)
                begin
                    if (sum_reg > HEIGHT_MAX)
                    begin
                        height_reg <= pnf_pkg::HEIGHT_W'(HEIGHT_MAX);
                    end
                    else if (sum_reg < HEIGHT_MIN)
                    begin
                        height_reg <= pnf_pkg::HEIGHT_W'(HEIGHT_MIN);
                    end
                    else
                    begin
                        height_reg <= pnf_pkg::HEIGHT_W'(sum_reg);
                    end
                end
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_oct_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pnf_pkg::ST_IDLE && state_reg != pnf_pkg::ST_FIN) |-> (oct_reg < n_reg))
        else $error("octave counter ran past the octave count");

    a_amp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pnf_pkg::ST_IDLE) |-> (amp_reg <= AMP_ONE))
        else $error("amplitude above one");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && operation == pnf_pkg::OP_LOAD) |=> (state_reg == pnf_pkg::ST_IDLE))
        else $error("load transfer started an evaluation");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == pnf_pkg::ST_FIN))
        else $error("result appeared outside the final state");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the fractal 2D Perlin noise block.
module tb_top;

    localparam int TBL = 256;
    localparam int OCT_LIMIT = 16;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic operation;
    logic [7:0] table_index;
    logic [pnf_pkg::PERM_W-1:0] perm_value;
    logic signed [pnf_pkg::GRAD_W-1:0] grad_x;
    logic signed [pnf_pkg::GRAD_W-1:0] grad_y;
    logic signed [pnf_pkg::POINT_W-1:0] point_x;
    logic signed [pnf_pkg::POINT_W-1:0] point_y;
    logic out_valid;
    logic out_stall;
    logic signed [pnf_pkg::HEIGHT_W-1:0] height;
    logic psel;
    logic penable;
    logic pwrite;
    logic [pnf_pkg::CFG_ADDR_W-1:0] paddr;
    logic [pnf_pkg::CFG_DATA_W-1:0] pwdata;
    logic [pnf_pkg::CFG_DATA_W-1:0] prdata;
    logic pready;

    // Local copy of the block state used for prediction.
    logic [7:0] perm_copy [TBL];
    int grad_x_copy [TBL];
    int grad_y_copy [TBL];
    logic [4:0] octaves_copy;
    logic [15:0] gain_copy;
    logic [15:0] freq_copy;

    logic signed [pnf_pkg::HEIGHT_W-1:0] heights_pending [$];
    int errors;
    int idle_pct;
    int stall_pct;

    perlin_noise_fbm_2d u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .table_index(table_index), .perm_value(perm_value),
        .grad_x(grad_x), .grad_y(grad_y), .point_x(point_x), .point_y(point_y),
        .out_valid(out_valid), .out_stall(out_stall), .height(height),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint round_down_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint wrap48(longint v);
        return (v <<< 16) >>> 16;
    endfunction

    function automatic longint blend_curve(longint t);
        longint t2;
        longint t3;
        t2 = t * t;
        t3 = t2 * t;
        return round_down_shift(3 * t2 * 4096 - 2 * t3, 20);
    endfunction

    function automatic longint blend(longint s, longint a, longint b);
        return a + round_down_shift(s * (b - a), 16);
    endfunction

    function automatic longint corner_dot(int k, longint rx, longint ry);
        return longint'(grad_x_copy[k]) * rx + longint'(grad_y_copy[k]) * ry;
    endfunction

    function automatic longint octave_noise(longint x, longint y);
        int bx0, by0, bx1, by1, hi, hj;
        int c00, c10, c01, c11;
        longint rx0, ry0, rx1, ry1, sx, sy, a, b;
        bx0 = int'((x >>> 12) & 255);
        by0 = int'((y >>> 12) & 255);
        bx1 = (bx0 + 1) & 255;
        by1 = (by0 + 1) & 255;
        rx0 = x & 12'hfff;
        ry0 = y & 12'hfff;
        rx1 = rx0 - 4096;
        ry1 = ry0 - 4096;
        hi = perm_copy[bx0];
        hj = perm_copy[bx1];
        c00 = perm_copy[(hi + by0) & 255];
        c10 = perm_copy[(hj + by0) & 255];
        c01 = perm_copy[(hi + by1) & 255];
        c11 = perm_copy[(hj + by1) & 255];
        sx = blend_curve(rx0);
        sy = blend_curve(ry0);
        a = blend(sx, corner_dot(c00, rx0, ry0), corner_dot(c10, rx1, ry0));
        b = blend(sx, corner_dot(c01, rx0, ry1), corner_dot(c11, rx1, ry1));
        return round_down_shift(blend(sy, a, b), 10);
    endfunction

    function automatic logic signed [pnf_pkg::HEIGHT_W-1:0] fractal_height(
        logic signed [pnf_pkg::POINT_W-1:0] x0, logic signed [pnf_pkg::POINT_W-1:0] y0);
        longint px, py, amp, total;
        int n;
        px = x0;
        py = y0;
        amp = 65536;
        total = 0;
        n = (octaves_copy > OCT_LIMIT) ? OCT_LIMIT : octaves_copy;
        for (int k = 0; k < n; k++)
        begin
            total += round_down_shift(octave_noise(px, py) * amp, 16);
            amp = round_down_shift(amp * longint'(gain_copy), 16);
            px = wrap48(round_down_shift(px * longint'(freq_copy), 12));
            py = wrap48(round_down_shift(py * longint'(freq_copy), 12));
        end
        if (total > 1048575)
            total = 1048575;
        if (total < -1048576)
            total = -1048576;
        return total[pnf_pkg::HEIGHT_W-1:0];
    endfunction

    function automatic int clamp_gradient(logic signed [pnf_pkg::GRAD_W-1:0] g);
        int v;
        v = g;
        if (v > 16384)
            v = 16384;
        if (v < -16384)
            v = -16384;
        return v;
    endfunction

    // Sends one item and records what it should produce once it is accepted.
    task automatic send_item(logic op, logic [7:0] idx, logic [7:0] pv,
                             logic signed [15:0] gx, logic signed [15:0] gy,
                             logic signed [23:0] x, logic signed [23:0] y);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        table_index <= idx;
        perm_value <= pv;
        grad_x <= gx;
        grad_y <= gy;
        point_x <= x;
        point_y <= y;
        do
            @(posedge clk);
        while (in_stall);
        if (op == pnf_pkg::OP_LOAD)
        begin
            perm_copy[idx] = pv;
            grad_x_copy[idx] = clamp_gradient(gx);
            grad_y_copy[idx] = clamp_gradient(gy);
        end
        else
        begin
            heights_pending.push_back(fractal_height(x, y));
        end
    endtask

    task automatic send_load(logic [7:0] idx, logic signed [15:0] gx,
                             logic signed [15:0] gy);
        send_item(pnf_pkg::OP_LOAD, idx, 8'($urandom), gx, gy,
                  24'($urandom), 24'($urandom));
    endtask

    task automatic send_eval(logic signed [23:0] x, logic signed [23:0] y);
        send_item(pnf_pkg::OP_EVAL, 8'($urandom), 8'($urandom), 16'($urandom),
                  16'($urandom), x, y);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (heights_pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= pnf_pkg::CFG_ADDR_W'(4 * index);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            pnf_pkg::REG_OCTAVES: octaves_copy = value[4:0];
            pnf_pkg::REG_GAIN:    gain_copy = value[15:0];
            default:              freq_copy = value[15:0];
        endcase
    endtask

    task automatic set_config(logic [4:0] oct, logic [15:0] gain, logic [15:0] freq);
        wait_until_drained();
        write_register(pnf_pkg::REG_OCTAVES, 32'(oct));
        write_register(pnf_pkg::REG_GAIN, 32'(gain));
        write_register(pnf_pkg::REG_FREQ, 32'(freq));
    endtask

    // Every entry gets written first so that no point can read an unloaded entry.
    task automatic test_table_fill();
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        for (int i = 0; i < TBL; i++)
        begin
            case (i % 6)
                0: begin gx = 16'sh7fff; gy = 16'sh8000; end
                1: begin gx = 16'sh4000; gy = -16'sh4000; end
                2: begin gx = -16'sh4001; gy = 16'sh4001; end
                default: begin gx = 16'($urandom); gy = 16'($urandom); end
            endcase
            send_load(8'(i), gx, gy);
        end
    endtask

    task automatic test_directed_points();
        send_eval(24'sd0, 24'sd0);
        send_eval(24'sh7fffff, 24'sh7fffff);
        send_eval(24'sh800000, 24'sh800000);
        send_eval(-24'sd1, -24'sd1);
        send_eval(24'sh000fff, 24'sh001000);
        send_eval(24'sh0ff800, -24'sh000800);
        send_eval(24'sh7fffff, 24'sh800000);
        send_load(8'd255, 16'sh7fff, 16'sh8000);
        send_load(8'd0, 16'sd0, 16'sh4000);
        send_eval(24'sh000800, 24'sh000800);
    endtask

    task automatic test_register_extremes();
        set_config(5'd0, 16'd19859, 16'd9011);
        send_eval(24'sh123456, -24'sh012345);
        set_config(5'd1, 16'd65535, 16'd65535);
        send_eval(24'sh7fffff, 24'sh7fffff);
        send_eval(24'sh400800, 24'sh800000);
        set_config(5'd16, 16'd0, 16'd0);
        send_eval(24'sh001234, 24'sh004321);
        set_config(5'd31, 16'd65535, 16'd65535);
        send_eval(24'sh7fffff, 24'sh800000);
        send_eval(-24'sd1, 24'sd1);
        set_config(5'd17, 16'd32768, 16'd8192);
        send_eval(24'sh00a000, 24'sh017fff);
        set_config(5'd16, 16'd65535, 16'd4096);
        send_eval(24'sh7ff000, 24'sh7ff000);
    endtask

    task automatic test_random_mix(int items);
        logic [4:0] oct;
        for (int i = 0; i < items; i++)
        begin
            // The first stretch runs with no idling on either side.
            idle_pct = (i < 60) ? 0 : 30;
            stall_pct = (i < 60) ? 0 : 30;
            if (i % 100 == 99)
            begin
                oct = (i % 200 == 99) ? 5'($urandom_range(1, 6)) : 5'($urandom);
                set_config(oct, 16'($urandom), 16'($urandom));
            end
            if ($urandom_range(99) < 55)
                send_eval(24'($urandom), 24'($urandom));
            else
                send_load(8'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Checks every height transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (heights_pending.size() == 0)
            begin
                $error("height: unexpected transfer, actual %0d", height);
                errors++;
            end
            else
            begin
                if (height !== heights_pending[0])
                begin
                    $error("height: expected %0d, actual %0d", heights_pending[0], height);
                    errors++;
                end
                void'(heights_pending.pop_front());
            end
        end
    end

    initial
    begin
        #4ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        errors = 0;
        idle_pct = 30;
        stall_pct = 30;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = pnf_pkg::OP_LOAD;
        table_index = '0;
        perm_value = '0;
        grad_x = '0;
        grad_y = '0;
        point_x = '0;
        point_y = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        octaves_copy = pnf_pkg::OCTAVES_RST;
        gain_copy = pnf_pkg::GAIN_RST;
        freq_copy = pnf_pkg::FREQ_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_directed_points();
        test_register_extremes();
        set_config(pnf_pkg::OCTAVES_RST, pnf_pkg::GAIN_RST, pnf_pkg::FREQ_RST);
        test_random_mix(130);
        wait_until_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[files.f]
design/pnf_pkg.sv
design/pnf_cfg.sv
design/pnf_tables.sv
design/pnf_mul.sv
design/perlin_noise_fbm_2d.sv
bench/tb_top.sv
